/* rtl/lcar_pkg.sv */
// Shared types and constants for the load cell converter reader and scaler.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package lcar_pkg;

    localparam int DATA_BITS = 24;

    localparam logic [DATA_BITS-1:0] MSB_FLIP   = 24'h800000;
    localparam logic [9:0]           WEIGHT_DIV = 10'd1000;
    // floor(2^40 / 1000): estimate is low by at most one
    localparam logic [30:0]          RECIP      = 31'd1099511627;
    localparam logic [6:0]           MIN_WINDOW = 7'd5;
    localparam logic [6:0]           MAX_WINDOW = 7'd100;

    typedef enum logic [1:0]
    {
        PH_WAIT  = 2'd0,
        PH_SHIFT = 2'd1,
        PH_FINAL = 2'd2
    } phase_t;

    typedef enum logic [7:0]
    {
        REG_ZERO_OFFSET = 8'd0,
        REG_SCALE       = 8'd1,
        REG_HALF_PERIOD = 8'd2,
        REG_FINAL_PULSE = 8'd3
    } cfg_index_t;

    typedef struct packed
    {
        logic                 clock_level;
        logic                 done;
        logic [DATA_BITS-1:0] raw;
    } tick_t;

endpackage

/* rtl/lcar_serial_ctrl.sv */
// Serial clock sequencer: waits for data ready, clocks in the reading, gain pulse.
// Depends on lcar_pkg.
`timescale 1ns / 1ps

module lcar_serial_ctrl
    import lcar_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        data_level,
    input  logic [7:0]  half_period,
    input  logic [9:0]  final_pulse,
    output tick_t       tick
);

    phase_t               phase_reg, phase_next;
    logic [4:0]           bit_reg, bit_next;
    logic [DATA_BITS-1:0] shift_reg, shift_next;
    logic [9:0]           tick_reg, tick_next;
    logic                 clk_reg, clk_next;
    logic [10:0]          tick_inc;
    logic                 done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            bit_reg   <= '0;
            shift_reg <= '0;
            tick_reg  <= '0;
            clk_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            tick_reg  <= tick_next;
            clk_reg   <= clk_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        tick_next  = tick_reg;
        clk_next   = clk_reg;
        done       = 1'b0;
        tick_inc   = {1'b0, tick_reg} + 11'd1;
        case (phase_reg)
            PH_SHIFT:
            begin
                if (tick_inc >= {3'b000, half_period})
                begin
                    tick_next = '0;
                    if (clk_reg)
                    begin
                        clk_next = 1'b0;
                    end
                    else
                    begin
                        shift_next = {shift_reg[DATA_BITS-2:0], data_level};
                        bit_next   = bit_reg + 5'd1;
                        clk_next   = 1'b1;
                        if (bit_next >= 5'(DATA_BITS))
                        begin
                            phase_next = PH_FINAL;
                        end
                    end
                end
                else
                begin
                    tick_next = tick_inc[9:0];
                end
            end
            PH_FINAL:
            begin
                if (tick_inc >= {1'b0, final_pulse})
                begin
                    tick_next  = '0;
                    clk_next   = 1'b0;
                    phase_next = PH_WAIT;
                    done       = 1'b1;
                end
                else
                begin
                    tick_next = tick_inc[9:0];
                end
            end
            default:
            begin
                phase_next = PH_WAIT;
                clk_next   = 1'b0;
                if (!data_level)
                begin
                    phase_next = PH_SHIFT;
                    clk_next   = 1'b1;
                    tick_next  = '0;
                    bit_next   = '0;
                    shift_next = '0;
                end
            end
        endcase
    end

    assign tick.clock_level = clk_next;
    assign tick.done        = done;
    assign tick.raw         = done ? (shift_reg ^ MSB_FLIP) : '0;

endmodule

/* rtl/lcar_scale_pipe.sv */
// Seven-stage scaling pipeline: offset, multiply, reciprocal divide by 1000.
// Depends on lcar_pkg. Each stage holds or collapses bubbles independently.
`timescale 1ns / 1ps

module lcar_scale_pipe
    import lcar_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tick_t                tick_in,
    input  logic [DATA_BITS-1:0] zero_offset,
    input  logic [15:0]          scale_factor,
    output logic                 res_valid,
    input  logic                 res_ready,
    output tick_t                res_tick,
    output logic signed [31:0]   res_weight
);

    localparam int PIPE_STAGES = 7;

    logic [PIPE_STAGES-1:0] v_reg;
    logic [PIPE_STAGES-1:0] v_in;
    logic [PIPE_STAGES:0]   rdy;
    tick_t                  tk_reg [PIPE_STAGES];

    logic                 neg2_reg, neg3_reg, neg4_reg, neg5_reg, neg6_reg;
    logic [DATA_BITS-1:0] absd2_reg;
    logic [39:0]          mag3_reg, mag4_reg, mag5_reg, mag6_reg;
    logic [50:0]          pphi4_reg, pplo4_reg;
    logic [30:0]          q05_reg, q06_reg;
    logic [40:0]          t6_reg;
    logic [31:0]          w7_reg;

    logic [DATA_BITS:0]   diff;
    logic [DATA_BITS:0]   diff_abs;
    logic [70:0]          est_sum;
    logic [39:0]          rem;
    logic [30:0]          quot;
    logic [31:0]          quot_ext;
    logic [31:0]          w_next;

    always_comb
    begin
        rdy[PIPE_STAGES] = res_ready;
        for (int k = PIPE_STAGES - 1; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign in_ready = rdy[0];
    assign v_in     = {v_reg[PIPE_STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < PIPE_STAGES; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_in[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            tk_reg[0] <= tick_in;
        end
        for (int k = 1; k < PIPE_STAGES; k++)
        begin
            if (rdy[k])
            begin
                tk_reg[k] <= tk_reg[k-1];
            end
        end
    end

    // raw minus offset, as sign and magnitude
    assign diff     = {1'b0, tk_reg[0].raw} - {1'b0, zero_offset};
    assign diff_abs = diff[DATA_BITS] ? -diff : diff;

    assign est_sum  = {pphi4_reg, 20'd0} + {20'd0, pplo4_reg};

    assign rem      = mag6_reg - t6_reg[39:0];
    assign quot     = q06_reg + {30'd0, (rem >= {30'd0, WEIGHT_DIV})};
    assign quot_ext = {1'b0, quot};

    always_comb
    begin
        w_next = neg6_reg ? -quot_ext : quot_ext;
        if (!tk_reg[5].done)
        begin
            w_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            neg2_reg  <= diff[DATA_BITS];
            absd2_reg <= diff_abs[DATA_BITS-1:0];
        end
        if (rdy[2])
        begin
            neg3_reg <= neg2_reg;
            mag3_reg <= {16'd0, absd2_reg} * {24'd0, scale_factor};
        end
        if (rdy[3])
        begin
            neg4_reg  <= neg3_reg;
            mag4_reg  <= mag3_reg;
            pphi4_reg <= {31'd0, mag3_reg[39:20]} * {20'd0, RECIP};
            pplo4_reg <= {31'd0, mag3_reg[19:0]} * {20'd0, RECIP};
        end
        if (rdy[4])
        begin
            neg5_reg <= neg4_reg;
            mag5_reg <= mag4_reg;
            q05_reg  <= est_sum[70:40];
        end
        if (rdy[5])
        begin
            neg6_reg <= neg5_reg;
            mag6_reg <= mag5_reg;
            q06_reg  <= q05_reg;
            t6_reg   <= {10'd0, q05_reg} * {31'd0, WEIGHT_DIV};
        end
        if (rdy[6])
        begin
            w7_reg <= w_next;
        end
    end

    assign res_valid  = v_reg[PIPE_STAGES-1];
    assign res_tick   = tk_reg[PIPE_STAGES-1];
    assign res_weight = signed'(w7_reg);

endmodule

/* rtl/load_cell_adc_reader_scaler.sv */
// Load cell converter reader and scaler: top level, configuration, stability window.
// Depends on lcar_pkg, lcar_serial_ctrl, lcar_scale_pipe.
//
//   channel  handshake            payload
//   in       in_valid/in_ready    data_level
//   out      out_valid/out_ready  clock_level reading_valid raw_count weight assured
//   cfg      cfg_valid/cfg_ready  cfg_index cfg_data
//
// One tick request is taken every cycle while in_ready is high; each gives one result,
// in order, through the seven-stage scaling pipeline and the output register.
// cfg_ready is always high. Reset clears the sequencer, the window count, the
// previous weight and all valid bits. A stalled output fills pipeline bubbles
// first; in_ready falls only once every stage holds a request.
`timescale 1ns / 1ps

module load_cell_adc_reader_scaler
    import lcar_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 data_level,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 clock_level,
    output logic                 reading_valid,
    output logic [DATA_BITS-1:0] raw_count,
    output logic signed [31:0]   weight,
    output logic                 assured,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_index,
    input  logic [23:0]          cfg_data
);

    logic [DATA_BITS-1:0] offset_reg;
    logic [15:0]          scale_reg;
    logic [7:0]           half_reg;
    logic [9:0]           final_reg;

    tick_t                tick;
    logic                 res_valid;
    tick_t                res_tick;
    logic signed [31:0]   res_weight;
    logic                 out_load;

    logic                 out_valid_reg;
    logic                 clock_reg, rvalid_reg, assured_reg;
    logic [DATA_BITS-1:0] raw_reg;
    logic signed [31:0]   weight_reg;
    logic signed [31:0]   prev_weight_reg;
    logic [6:0]           window_reg, window_next;
    logic                 assured_next;
    logic [6:0]           win_inc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            scale_reg  <= 16'd1000;
            half_reg   <= 8'd1;
            final_reg  <= 10'd5;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ZERO_OFFSET: offset_reg <= cfg_data[DATA_BITS-1:0];
                REG_SCALE:       scale_reg  <= cfg_data[15:0];
                REG_HALF_PERIOD: half_reg   <= cfg_data[7:0];
                REG_FINAL_PULSE: final_reg  <= cfg_data[9:0];
                default:         ;
            endcase
        end
    end

    lcar_serial_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_valid && in_ready),
        .data_level  (data_level),
        .half_period (half_reg),
        .final_pulse (final_reg),
        .tick        (tick)
    );

    lcar_scale_pipe u_pipe
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .tick_in      (tick),
        .zero_offset  (offset_reg),
        .scale_factor (scale_reg),
        .res_valid    (res_valid),
        .res_ready    (out_load),
        .res_tick     (res_tick),
        .res_weight   (res_weight)
    );

    assign out_load = !out_valid_reg || out_ready;

    // stability window: fifth or later reading matching the last, or the limit
    always_comb
    begin
        win_inc      = window_reg + 7'd1;
        assured_next = res_tick.done &&
                       (((win_inc >= MIN_WINDOW) && (res_weight == prev_weight_reg)) ||
                        (win_inc >= MAX_WINDOW));
        window_next  = assured_next ? 7'd0 : win_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            window_reg      <= '0;
            prev_weight_reg <= '0;
        end
        else if (out_load)
        begin
            out_valid_reg <= res_valid;
            if (res_valid && res_tick.done)
            begin
                window_reg      <= window_next;
                prev_weight_reg <= res_weight;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            clock_reg   <= res_tick.clock_level;
            rvalid_reg  <= res_tick.done;
            raw_reg     <= res_tick.raw;
            weight_reg  <= res_weight;
            assured_reg <= assured_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign clock_level   = clock_reg;
    assign reading_valid = rvalid_reg;
    assign raw_count     = raw_reg;
    assign weight        = weight_reg;
    assign assured       = assured_reg;

endmodule

/* tb/tb_load_cell_adc_reader_scaler.sv */
// Self-checking bench for load_cell_adc_reader_scaler: drives pin-level tick requests
// and register writes, and checks every result, in order, against a per-tick predictor.
// Depends on lcar_pkg and the load_cell_adc_reader_scaler RTL.
`timescale 1ns / 1ps

import lcar_pkg::*;

localparam longint GRAM_DIV = 1000;

typedef struct packed
{
    logic                 clock_level;
    logic                 reading_valid;
    logic [DATA_BITS-1:0] raw_count;
    logic [31:0]          weight;
    logic                 assured;
} tick_out_t;

class weigh_scoreboard;
    logic [DATA_BITS-1:0] zero_offset;
    logic [15:0]          scale_factor;
    logic [7:0]           half_ticks;
    logic [9:0]           final_ticks;
    phase_t               phase;
    int unsigned          bits_done;
    logic [DATA_BITS-1:0] shift_reg;
    int unsigned          ticks;
    logic                 clk_out;
    longint               last_weight;
    int unsigned          window_reads;
    tick_out_t            result_q[$];
    int                   errors;
    int                   readings;

    function new();
        zero_offset  = '0;
        scale_factor = 16'd1000;
        half_ticks   = 8'd1;
        final_ticks  = 10'd5;
        phase        = PH_WAIT;
        bits_done    = 0;
        shift_reg    = '0;
        ticks        = 0;
        clk_out      = 1'b0;
        last_weight  = 0;
        window_reads = 0;
        errors       = 0;
        readings     = 0;
    endfunction

    function void set_reg(logic [7:0] idx, logic [23:0] val);
        case (idx)
            REG_ZERO_OFFSET: zero_offset  = val;
            REG_SCALE:       scale_factor = val[15:0];
            REG_HALF_PERIOD: half_ticks   = val[7:0];
            REG_FINAL_PULSE: final_ticks  = val[9:0];
            default: ;
        endcase
    endfunction

    function void note_tick(logic din);
        tick_out_t   r;
        int unsigned next;
        int unsigned n;
        longint      diff;
        longint      w;
        r    = '0;
        next = ticks + 1;
        case (phase)
            PH_SHIFT:
            begin
                if (next >= half_ticks)
                begin
                    ticks = 0;
                    if (clk_out)
                        clk_out = 1'b0;
                    else
                    begin
                        shift_reg = {shift_reg[DATA_BITS-2:0], din};
                        bits_done++;
                        clk_out = 1'b1;
                        if (bits_done >= DATA_BITS)
                            phase = PH_FINAL;
                    end
                end
                else
                    ticks = next;
            end
            PH_FINAL:
            begin
                if (next >= final_ticks)
                begin
                    ticks   = 0;
                    clk_out = 1'b0;
                    phase   = PH_WAIT;
                    r.raw_count     = shift_reg ^ MSB_FLIP;
                    diff            = longint'(r.raw_count) - longint'(zero_offset);
                    w               = diff * longint'(scale_factor) / GRAM_DIV;
                    r.reading_valid = 1'b1;
                    r.weight        = w[31:0];
                    n = window_reads + 1;
                    if ((n >= MIN_WINDOW && w == last_weight) || n >= MAX_WINDOW)
                    begin
                        r.assured    = 1'b1;
                        window_reads = 0;
                    end
                    else
                        window_reads = n;
                    last_weight = w;
                    readings++;
                end
                else
                    ticks = next;
            end
            default:
            begin
                // unused code falls back to waiting
                phase   = PH_WAIT;
                clk_out = 1'b0;
                if (!din)
                begin
                    phase     = PH_SHIFT;
                    clk_out   = 1'b1;
                    ticks     = 0;
                    bits_done = 0;
                    shift_reg = '0;
                end
            end
        endcase
        r.clock_level = clk_out;
        result_q.push_back(r);
    endfunction

    function void cmp(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            if (errors <= 200)
                $display("%0t %s: expected %0h, actual %0h", $time, what, want, got);
        end
    endfunction

    function void check(tick_out_t got);
        tick_out_t want;
        if (result_q.size() == 0)
        begin
            errors++;
            if (errors <= 200)
                $display("%0t unexpected result: expected none, actual %0h", $time, got);
            return;
        end
        want = result_q.pop_front();
        cmp("clock_level", 32'(want.clock_level), 32'(got.clock_level));
        cmp("reading_valid", 32'(want.reading_valid), 32'(got.reading_valid));
        cmp("raw_count", 32'(want.raw_count), 32'(got.raw_count));
        cmp("weight", want.weight, got.weight);
        cmp("assured", 32'(want.assured), 32'(got.assured));
    endfunction

    function int pending();
        return result_q.size();
    endfunction
endclass

module tb_load_cell_adc_reader_scaler;

    localparam int unsigned CYCLE_LIMIT  = 4000000;
    localparam int          DRAIN_CYCLES = 16;
    localparam logic [7:0]  REG_SPARE    = 8'd4;
    localparam logic [7:0]  REG_TOP      = 8'hFF;

    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic                 data_level  = 1'b1;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic                 clock_level;
    logic                 reading_valid;
    logic [DATA_BITS-1:0] raw_count;
    logic signed [31:0]   weight;
    logic                 assured;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [7:0]           cfg_index   = '0;
    logic [23:0]          cfg_data    = '0;

    weigh_scoreboard      sb;
    logic [DATA_BITS-1:0] target;
    int                   lead_high;
    int                   repeat_pct;
    int                   noise_pct;
    bit                   tx_burst;
    bit                   hold_request;

    load_cell_adc_reader_scaler uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_level    (data_level),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .clock_level   (clock_level),
        .reading_valid (reading_valid),
        .raw_count     (raw_count),
        .weight        (weight),
        .assured       (assured),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [DATA_BITS-1:0] fresh_target();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return MSB_FLIP;
            3:       return ~MSB_FLIP;
            default: return 24'($urandom_range(0, 24'hFFFFFF));
        endcase
    endfunction

    // level for the next tick, following the predicted sequencer state
    function automatic logic pick_level();
        if ($urandom_range(0, 99) < noise_pct)
            return 1'($urandom_range(0, 1));
        if (sb.phase == PH_SHIFT)
            return target[DATA_BITS-1-sb.bits_done];
        if (sb.phase == PH_FINAL)
            return 1'($urandom_range(0, 1));
        if (lead_high > 0)
        begin
            lead_high--;
            return 1'b1;
        end
        if ($urandom_range(0, 99) >= repeat_pct)
            target = fresh_target();
        lead_high = $urandom_range(0, 5);
        return 1'b0;
    endfunction

    task automatic send_tick();
        int gap;
        if ($urandom_range(0, 99) < 2)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_level <= pick_level();
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_tick(data_level);
    endtask

    task automatic pause_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_readings(int count);
        int goal;
        goal = sb.readings + count;
        while (sb.readings < goal)
            send_tick();
        pause_input();
    endtask

    task automatic read_fixed(logic [DATA_BITS-1:0] v);
        target     = v;
        repeat_pct = 100;
        run_readings(1);
    endtask

    task automatic settle();
        pause_input();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : result_sink
        int        rx_wait;
        int        hold_left;
        bit        held;
        bit        rx_burst;
        tick_out_t got;
        rx_wait   = 0;
        hold_left = 0;
        held      = 1'b0;
        rx_burst  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got.clock_level   = clock_level;
                got.reading_valid = reading_valid;
                got.raw_count     = raw_count;
                got.weight        = weight;
                got.assured       = assured;
                sb.check(got);
                if ($urandom_range(0, 99) < 3)
                    rx_burst = !rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, 17);
            end
            if (hold_request && !held)
            begin
                held      = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("load_cell_adc_reader_scaler: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        logic [7:0]  junk;
        logic [15:0] scale;
        sb           = new();
        target       = '0;
        lead_high    = 2;
        repeat_pct   = 100;
        noise_pct    = 0;
        tx_burst     = 1'b0;
        hold_request = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, raw extremes either side of the sign flip
        read_fixed(24'h000000);
        read_fixed(24'hFFFFFF);
        settle();

        // full offset and scale, zero timing registers, writes to unused indexes
        write_reg(REG_ZERO_OFFSET, 24'hFFFFFF);
        write_reg(REG_SCALE, 24'h00FFFF);
        write_reg(REG_HALF_PERIOD, 24'h000000);
        write_reg(REG_FINAL_PULSE, 24'h000000);
        write_reg(REG_SPARE, 24'h5A5A5A);
        write_reg(REG_TOP, 24'hA5A5A5);
        read_fixed(24'h800000);
        read_fixed(24'h7FFFFF);
        settle();
        write_reg(REG_ZERO_OFFSET, 24'h000000);
        read_fixed(24'h7FFFFF);
        settle();

        // bits above each register width are dropped; data toggles while shifting
        write_reg(REG_SCALE, 24'hABCDEF);
        write_reg(REG_HALF_PERIOD, 24'hFFFF02);
        write_reg(REG_FINAL_PULSE, 24'hFFFC03);
        write_reg(REG_ZERO_OFFSET, 24'h123456);
        noise_pct = 20;
        read_fixed(24'h5A5A5A);
        settle();

        // repeated readings under a long output stall so the window qualifies
        junk  = 8'($urandom_range(0, 255));
        scale = 16'($urandom_range(0, 16'hFFFF));
        write_reg(REG_ZERO_OFFSET, 24'($urandom_range(0, 24'hFFFFFF)));
        write_reg(REG_SCALE, {junk, scale});
        write_reg(REG_HALF_PERIOD, {junk, junk, 8'($urandom_range(0, 1))});
        write_reg(REG_FINAL_PULSE, {junk, junk[5:0], 10'($urandom_range(0, 4))});
        target       = fresh_target();
        repeat_pct   = 100;
        noise_pct    = 0;
        hold_request = 1'b1;
        run_readings(7);
        settle();

        if (sb.errors == 0)
            $display("load_cell_adc_reader_scaler: match");
        else
            $display("load_cell_adc_reader_scaler: mismatch");
        $finish;
    end

endmodule

/* load_cell_adc_reader_scaler.f */
rtl/lcar_pkg.sv
rtl/lcar_serial_ctrl.sv
rtl/lcar_scale_pipe.sv
rtl/load_cell_adc_reader_scaler.sv
tb/tb_load_cell_adc_reader_scaler.sv
